[rtl/ceps_pkg.sv]
// ----------------------------------------------------------------------------
// Cartoon eye pixel shader package
// Register map, shading constants and the configuration bundle.
// ----------------------------------------------------------------------------
package ceps_pkg;

	localparam int CFG_IW = 3;
	localparam int CFG_DW = 24;

	localparam logic [CFG_IW-1:0] REG_PUPIL_DX      = 3'd0;
	localparam logic [CFG_IW-1:0] REG_PUPIL_DY      = 3'd1;
	localparam logic [CFG_IW-1:0] REG_IRIS_RGB      = 3'd2;
	localparam logic [CFG_IW-1:0] REG_HIGHLIGHT     = 3'd3;
	localparam logic [CFG_IW-1:0] REG_EYELID_ROWS   = 3'd4;
	localparam logic [CFG_IW-1:0] REG_CLOSED_EYE    = 3'd5;

	localparam logic [1:0] HL_NONE = 2'd0;
	localparam logic [1:0] HL_DOT  = 2'd1;
	localparam logic [1:0] HL_STAR = 2'd2;

	localparam logic [23:0] IRIS_RESET = 24'h0096C8;
	localparam logic [23:0] LID_RGB    = 24'hFFC800;
	localparam logic [23:0] WHITE_RGB  = 24'hFFFFFF;
	localparam logic [23:0] BLACK_RGB  = 24'h000000;

	localparam int EYE_R       = 120;
	localparam int EYE_R2      = 14400;
	localparam int PUPIL_R2    = 5625;
	localparam int IRIS_R2     = 7569;
	localparam int HL_OFF      = 30;
	localparam int HL_R        = 20;
	localparam int HL_R2       = 400;
	localparam int SLIT_SHIFT  = 6;
	localparam int ELLIPSE_LIM = 921600;

	typedef struct packed {
		logic [5:0]  pupil_dx;
		logic [5:0]  pupil_dy;
		logic [23:0] iris_rgb;
		logic [1:0]  highlight_mode;
		logic [7:0]  eyelid_rows;
		logic        closed_eye;
	} cfg_t;

endpackage

[rtl/ceps_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Cartoon eye configuration registers
// Write-only register file; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module ceps_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ceps_pkg::CFG_IW-1:0]   cfg_index,
	input  logic [ceps_pkg::CFG_DW-1:0]   cfg_data,
	output ceps_pkg::cfg_t                cfg
);

	ceps_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pupil_dx       <= 6'd0;
			cfg_q.pupil_dy       <= 6'd0;
			cfg_q.iris_rgb       <= ceps_pkg::IRIS_RESET;
			cfg_q.highlight_mode <= ceps_pkg::HL_DOT;
			cfg_q.eyelid_rows    <= 8'd0;
			cfg_q.closed_eye     <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ceps_pkg::REG_PUPIL_DX:    cfg_q.pupil_dx       <= cfg_data[5:0];
				ceps_pkg::REG_PUPIL_DY:    cfg_q.pupil_dy       <= cfg_data[5:0];
				ceps_pkg::REG_IRIS_RGB:    cfg_q.iris_rgb       <= cfg_data[23:0];
				ceps_pkg::REG_HIGHLIGHT:   cfg_q.highlight_mode <= cfg_data[1:0];
				ceps_pkg::REG_EYELID_ROWS: cfg_q.eyelid_rows    <= cfg_data[7:0];
				ceps_pkg::REG_CLOSED_EYE:  cfg_q.closed_eye     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/cartoon_eye_pixel_shader.sv]
// ----------------------------------------------------------------------------
// Cartoon eye pixel shader
// Four register stages lie between input transfer and out_valid
// (offsets, squares, sums and products, compare and color select into the output register).
// Throughput: one pixel per cycle; a held output stalls only a full pipeline.
// Reset: valid bits clear, configuration registers load their defaults.
// ----------------------------------------------------------------------------
module cartoon_eye_pixel_shader #(
	parameter int SCREEN_W = 240,
	parameter int SCREEN_H = 240
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ceps_pkg::CFG_IW-1:0]   cfg_index,
	input  logic [ceps_pkg::CFG_DW-1:0]   cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    pixel_x,
	input  logic [7:0]                    pixel_y,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    red,
	output logic [7:0]                    green,
	output logic [7:0]                    blue
);

	localparam int MAXD = (SCREEN_W > SCREEN_H) ? SCREEN_W : SCREEN_H;
	localparam int CW   = $clog2(MAXD + 1);
	localparam int DW   = $clog2(MAXD / 2 + 256) + 1;
	localparam int MW   = DW - 1;
	localparam int SQW  = 2 * MW;
	localparam int SW   = SQW + 1;
	localparam int EW   = SQW + 15;

	localparam logic signed [DW-1:0] CX = DW'(SCREEN_W / 2);
	localparam logic signed [DW-1:0] CY = DW'(SCREEN_H / 2);

	ceps_pkg::cfg_t cfg;

	ceps_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	assign rdy4     = !v_s4 || !out_stall;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// stage 1: offsets from eye, pupil and highlight centers
	logic signed [DW-1:0] x_ext, y_ext, ex_c, ey_c, pdx_c, pdy_c, offx, offy;
	logic                 on_c;

	assign x_ext = $signed(DW'(pixel_x));
	assign y_ext = $signed(DW'(pixel_y));
	assign offx  = DW'($signed(cfg.pupil_dx));
	assign offy  = DW'($signed(cfg.pupil_dy));
	assign ex_c  = x_ext - CX;
	assign ey_c  = y_ext - CY;
	assign pdx_c = ex_c - offx;
	assign pdy_c = ey_c - offy;
	assign on_c  = (CW'(pixel_x) < CW'(SCREEN_W)) && (CW'(pixel_y) < CW'(SCREEN_H));

	logic signed [DW-1:0] ex_s1, ey_s1, pdx_s1, pdy_s1, hdx_s1, hdy_s1;
	logic                 on_s1;

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			ex_s1  <= ex_c;
			ey_s1  <= ey_c;
			pdx_s1 <= pdx_c;
			pdy_s1 <= pdy_c;
			hdx_s1 <= pdx_c + DW'(ceps_pkg::HL_OFF);
			hdy_s1 <= pdy_c + DW'(ceps_pkg::HL_OFF);
			on_s1  <= on_c;
		end
	end

	// stage 2: squares, diamond distance, eyelid row
	function automatic logic [MW-1:0] mag(input logic signed [DW-1:0] v);
		logic signed [DW-1:0] n;
		n = -v;
		return v[DW-1] ? MW'(n) : MW'(v);
	endfunction

	logic [MW-1:0] m_ex, m_ey, m_px, m_py, m_hx, m_hy;

	assign m_ex = mag(ex_s1);
	assign m_ey = mag(ey_s1);
	assign m_px = mag(pdx_s1);
	assign m_py = mag(pdy_s1);
	assign m_hx = mag(hdx_s1);
	assign m_hy = mag(hdy_s1);

	logic [SQW-1:0] ex2_s2, ey2_s2, px2_s2, py2_s2, hx2_s2, hy2_s2;
	logic [MW:0]    man_s2;
	logic           lid_s2, on_s2;

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			ex2_s2 <= SQW'(m_ex) * SQW'(m_ex);
			ey2_s2 <= SQW'(m_ey) * SQW'(m_ey);
			px2_s2 <= SQW'(m_px) * SQW'(m_px);
			py2_s2 <= SQW'(m_py) * SQW'(m_py);
			hx2_s2 <= SQW'(m_hx) * SQW'(m_hx);
			hy2_s2 <= SQW'(m_hy) * SQW'(m_hy);
			man_s2 <= (MW+1)'(m_hx) + (MW+1)'(m_hy);
			lid_s2 <= (ey_s1 + DW'(ceps_pkg::EYE_R)) < $signed(DW'(cfg.eyelid_rows));
			on_s2  <= on_s1;
		end
	end

	// stage 3: distance sums and ellipse terms
	logic [SW-1:0] eye_d2_s3, pd2_s3, hd2_s3;
	logic [EW-1:0] ell_s3;
	logic [MW:0]   man_s3;
	logic          lid_s3, on_s3;

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			eye_d2_s3 <= SW'(ex2_s2) + SW'(ey2_s2);
			pd2_s3    <= SW'(px2_s2) + SW'(py2_s2);
			hd2_s3    <= SW'(hx2_s2) + SW'(hy2_s2);
			ell_s3    <= (EW'(ex2_s2) << ceps_pkg::SLIT_SHIFT)
				+ EW'(ey2_s2) * EW'(ceps_pkg::EYE_R2);
			man_s3    <= man_s2;
			lid_s3    <= lid_s2;
			on_s3     <= on_s2;
		end
	end

	// stage 4: layer compares and color select
	logic        in_eye, in_pupil, in_iris, in_dot, in_star, in_ell;
	logic [23:0] rgb_c;

	assign in_eye   = eye_d2_s3 <= SW'(ceps_pkg::EYE_R2);
	assign in_pupil = pd2_s3 <= SW'(ceps_pkg::PUPIL_R2);
	assign in_iris  = !in_pupil && (pd2_s3 <= SW'(ceps_pkg::IRIS_R2));
	assign in_dot   = (cfg.highlight_mode == ceps_pkg::HL_DOT)
		&& (hd2_s3 <= SW'(ceps_pkg::HL_R2));
	assign in_star  = (cfg.highlight_mode == ceps_pkg::HL_STAR)
		&& (man_s3 <= (MW+1)'(ceps_pkg::HL_R));
	assign in_ell   = ell_s3 <= EW'(ceps_pkg::ELLIPSE_LIM);

	always_comb begin
		rgb_c = ceps_pkg::BLACK_RGB;
		if (!on_s3) begin
			rgb_c = ceps_pkg::BLACK_RGB;
		end else if (cfg.closed_eye) begin
			rgb_c = in_ell ? ceps_pkg::LID_RGB : ceps_pkg::BLACK_RGB;
		end else begin
			if (in_eye) rgb_c = ceps_pkg::WHITE_RGB;
			if (in_pupil) rgb_c = ceps_pkg::BLACK_RGB;
			if (in_iris) rgb_c = cfg.iris_rgb;
			if (in_dot || in_star) rgb_c = ceps_pkg::WHITE_RGB;
			if (in_eye && lid_s3) rgb_c = ceps_pkg::LID_RGB;
		end
	end

	logic [7:0] red_s4, green_s4, blue_s4;

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			red_s4   <= rgb_c[23:16];
			green_s4 <= rgb_c[15:8];
			blue_s4  <= rgb_c[7:0];
		end
	end

	assign out_valid = v_s4;
	assign red       = red_s4;
	assign green     = green_s4;
	assign blue      = blue_s4;

`ifndef ASSERT_OFF
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && v_s3 && v_s4 && out_stall))
		else $error("input stalled with a free pipeline slot");

	a_offscreen_black: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && rdy4 && !on_s3) |=> (red == 8'd0 && green == 8'd0 && blue == 8'd0))
		else $error("off-screen pixel not black");

	a_advance_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && rdy4) |=> out_valid)
		else $error("stage 3 item lost on advance");
`endif

endmodule

[tb/cartoon_eye_pixel_shader_tb.sv]
// ----------------------------------------------------------------------------
// Cartoon eye pixel shader testbench
// Streams pixel coordinates through the shader under a series of register
// settings. Each color is checked against a probe's expected color or an in-bench model of the eye layers.
// A short table of probe pixels comes first, then random pixels aimed at the
// layer edges. Sender gaps and receiver stalls are randomized.
// ----------------------------------------------------------------------------
module cartoon_eye_pixel_shader_tb;

	localparam int SCREEN_W        = 240;
	localparam int SCREEN_H        = 240;
	localparam int EYE_RADIUS      = 120;
	localparam int IRIS_INNER      = 75;
	localparam int IRIS_OUTER      = 87;
	localparam int SPOT_RADIUS     = 20;
	localparam int SPOT_SHIFT      = 30;
	localparam int SLIT_RY         = 8;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int PHASE_COUNT     = 12;
	localparam int ITEMS_PER_PHASE = 152;
	localparam int SETTLE_CYCLES   = 8;
	localparam int PROBE_COUNT     = 25;
	localparam int CLOSED_FIRST    = 18;

	localparam logic [ceps_pkg::CFG_IW-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [ceps_pkg::CFG_IW-1:0] REG_SPARE_7 = 3'd7;
	localparam logic [1:0]                  HL_UNUSED   = 2'd3;

	typedef struct packed {
		logic [7:0]  x;
		logic [7:0]  y;
		logic        typed;
		logic [23:0] rgb;
	} probe_t;

	localparam probe_t PROBES [PROBE_COUNT] = '{
		'{8'd240, 8'd0,   1'b1, ceps_pkg::BLACK_RGB},
		'{8'd0,   8'd240, 1'b1, ceps_pkg::BLACK_RGB},
		'{8'd255, 8'd255, 1'b1, ceps_pkg::BLACK_RGB},
		'{8'd0,   8'd0,   1'b1, ceps_pkg::BLACK_RGB},
		'{8'd239, 8'd239, 1'b1, ceps_pkg::BLACK_RGB},
		'{8'd120, 8'd120, 1'b1, ceps_pkg::BLACK_RGB},
		'{8'd120, 8'd0,   1'b1, ceps_pkg::WHITE_RGB},
		'{8'd0,   8'd120, 1'b1, ceps_pkg::WHITE_RGB},
		'{8'd239, 8'd120, 1'b1, ceps_pkg::WHITE_RGB},
		'{8'd120, 8'd239, 1'b1, ceps_pkg::WHITE_RGB},
		'{8'd120, 8'd200, 1'b1, ceps_pkg::IRIS_RESET},
		'{8'd90,  8'd90,  1'b1, ceps_pkg::WHITE_RGB},
		'{8'd120, 8'd45,  1'b0, ceps_pkg::BLACK_RGB},
		'{8'd120, 8'd44,  1'b0, ceps_pkg::BLACK_RGB},
		'{8'd120, 8'd33,  1'b0, ceps_pkg::BLACK_RGB},
		'{8'd120, 8'd32,  1'b0, ceps_pkg::BLACK_RGB},
		'{8'd110, 8'd90,  1'b0, ceps_pkg::BLACK_RGB},
		'{8'd111, 8'd90,  1'b0, ceps_pkg::BLACK_RGB},
		'{8'd120, 8'd120, 1'b1, ceps_pkg::LID_RGB},
		'{8'd0,   8'd120, 1'b1, ceps_pkg::LID_RGB},
		'{8'd120, 8'd112, 1'b1, ceps_pkg::LID_RGB},
		'{8'd120, 8'd111, 1'b1, ceps_pkg::BLACK_RGB},
		'{8'd240, 8'd120, 1'b1, ceps_pkg::BLACK_RGB},
		'{8'd120, 8'd128, 1'b1, ceps_pkg::LID_RGB},
		'{8'd239, 8'd120, 1'b0, ceps_pkg::BLACK_RGB}
	};

	localparam ceps_pkg::cfg_t PHASE_CFG [PHASE_COUNT] = '{
		'{6'h20, 6'h20, 24'hFFFFFF, ceps_pkg::HL_STAR, 8'd0,   1'b0},
		'{6'h1F, 6'h1F, 24'h000000, ceps_pkg::HL_DOT,  8'd1,   1'b0},
		'{6'h20, 6'h1F, 24'hA5C35A, ceps_pkg::HL_NONE, 8'd120, 1'b0},
		'{6'h1F, 6'h20, 24'h123456, HL_UNUSED,         8'd240, 1'b0},
		'{6'h00, 6'h00, 24'h0096C8, ceps_pkg::HL_STAR, 8'd255, 1'b0},
		'{6'h3F, 6'h01, 24'hFF00FF, ceps_pkg::HL_DOT,  8'd60,  1'b0},
		'{6'h00, 6'h00, 24'h000000, ceps_pkg::HL_DOT,  8'd0,   1'b1},
		'{6'h0A, 6'h2C, 24'h00FF00, ceps_pkg::HL_STAR, 8'd200, 1'b0},
		'{6'h3B, 6'h11, 24'h7F7F7F, ceps_pkg::HL_DOT,  8'd239, 1'b0},
		'{6'h1F, 6'h00, 24'hFFFFFF, ceps_pkg::HL_STAR, 8'd0,   1'b1},
		'{6'h00, 6'h1F, 24'h808080, ceps_pkg::HL_DOT,  8'd90,  1'b0},
		'{6'h2A, 6'h15, 24'h5A5A5A, ceps_pkg::HL_STAR, 8'd30,  1'b0}
	};

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        cfg_we;
	logic [ceps_pkg::CFG_IW-1:0] cfg_index;
	logic [ceps_pkg::CFG_DW-1:0] cfg_data;
	logic                        in_valid;
	logic                        in_stall;
	logic [7:0]                  pixel_x;
	logic [7:0]                  pixel_y;
	logic                        out_valid;
	logic                        out_stall;
	logic [7:0]                  red;
	logic [7:0]                  green;
	logic [7:0]                  blue;

	ceps_pkg::cfg_t model_cfg;
	logic [23:0]    expected_colors [$];
	int             error_count;
	int             cycle_count;
	int             send_idle_pct;
	int             sink_stall_pct;

	cartoon_eye_pixel_shader DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.red       (red),
		.green     (green),
		.blue      (blue)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
	end

	always @(posedge clk) begin
		logic [23:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_colors.size() == 0) begin
				$error("unexpected pixel: red %0d green %0d blue %0d", red, green, blue);
				error_count++;
			end else begin
				want = expected_colors.pop_front();
				if (red !== want[23:16]) begin
					$error("red: expected %0d, got %0d", want[23:16], red);
					error_count++;
				end
				if (green !== want[15:8]) begin
					$error("green: expected %0d, got %0d", want[15:8], green);
					error_count++;
				end
				if (blue !== want[7:0]) begin
					$error("blue: expected %0d, got %0d", want[7:0], blue);
					error_count++;
				end
			end
		end
	end

	function automatic logic [23:0] pixel_color(input logic [7:0] x_in, input logic [7:0] y_in);
		int          x;
		int          y;
		int          ex;
		int          ey;
		int          px;
		int          py;
		int          pd2;
		int          hdx;
		int          hdy;
		longint      slit;
		logic        in_eye;
		logic [23:0] c;
		x = int'(x_in);
		y = int'(y_in);
		if (x >= SCREEN_W || y >= SCREEN_H)
			return ceps_pkg::BLACK_RGB;
		ex = x - SCREEN_W / 2;
		ey = y - SCREEN_H / 2;
		if (model_cfg.closed_eye) begin
			slit = longint'(ex * ex) * SLIT_RY * SLIT_RY
				+ longint'(ey * ey) * EYE_RADIUS * EYE_RADIUS;
			return (slit <= longint'(EYE_RADIUS * EYE_RADIUS * SLIT_RY * SLIT_RY))
				? ceps_pkg::LID_RGB : ceps_pkg::BLACK_RGB;
		end
		in_eye = (ex * ex + ey * ey <= EYE_RADIUS * EYE_RADIUS);
		c = in_eye ? ceps_pkg::WHITE_RGB : ceps_pkg::BLACK_RGB;
		px = SCREEN_W / 2 + int'($signed(model_cfg.pupil_dx));
		py = SCREEN_H / 2 + int'($signed(model_cfg.pupil_dy));
		pd2 = (x - px) * (x - px) + (y - py) * (y - py);
		if (pd2 <= IRIS_INNER * IRIS_INNER)
			c = ceps_pkg::BLACK_RGB;
		else if (pd2 <= IRIS_OUTER * IRIS_OUTER)
			c = model_cfg.iris_rgb;
		hdx = x - (px - SPOT_SHIFT);
		hdy = y - (py - SPOT_SHIFT);
		case (model_cfg.highlight_mode)
			ceps_pkg::HL_DOT: begin
				if (hdx * hdx + hdy * hdy <= SPOT_RADIUS * SPOT_RADIUS)
					c = ceps_pkg::WHITE_RGB;
			end
			ceps_pkg::HL_STAR: begin
				if ((hdx < 0 ? -hdx : hdx) + (hdy < 0 ? -hdy : hdy) <= SPOT_RADIUS)
					c = ceps_pkg::WHITE_RGB;
			end
			default: ;
		endcase
		if (in_eye && ey + EYE_RADIUS < int'(model_cfg.eyelid_rows))
			c = ceps_pkg::LID_RGB;
		return c;
	endfunction

	function automatic logic [7:0] fit_byte(input int v);
		return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
	endfunction

	// aim most pixels at layer boundaries around the current pupil and lid
	function automatic logic [15:0] random_pixel();
		int x;
		int y;
		int cx;
		int cy;
		int pick;
		cx = SCREEN_W / 2 + int'($signed(model_cfg.pupil_dx));
		cy = SCREEN_H / 2 + int'($signed(model_cfg.pupil_dy));
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			x = $urandom_range(0, 255);
			y = $urandom_range(SCREEN_H, 255);
			if ($urandom_range(0, 1)) begin
				int t;
				t = x;
				x = y;
				y = t;
			end
		end else if (pick < 30) begin
			x = cx - SPOT_SHIFT + int'($urandom_range(0, 50)) - 25;
			y = cy - SPOT_SHIFT + int'($urandom_range(0, 50)) - 25;
		end else if (pick < 55) begin
			x = cx + int'($urandom_range(0, 180)) - 90;
			y = cy + int'($urandom_range(0, 180)) - 90;
		end else if (pick < 68) begin
			x = $urandom_range(0, SCREEN_W - 1);
			y = SCREEN_H / 2 + int'($urandom_range(0, 24)) - 12;
		end else if (pick < 80) begin
			x = $urandom_range(0, SCREEN_W - 1);
			y = int'(model_cfg.eyelid_rows) + int'($urandom_range(0, 6)) - 3;
		end else begin
			x = $urandom_range(0, SCREEN_W - 1);
			y = $urandom_range(0, SCREEN_H - 1);
		end
		return {fit_byte(x), fit_byte(y)};
	endfunction

	task automatic write_reg(input logic [ceps_pkg::CFG_IW-1:0] idx,
			input logic [ceps_pkg::CFG_DW-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			ceps_pkg::REG_PUPIL_DX:    model_cfg.pupil_dx       = data[5:0];
			ceps_pkg::REG_PUPIL_DY:    model_cfg.pupil_dy       = data[5:0];
			ceps_pkg::REG_IRIS_RGB:    model_cfg.iris_rgb       = data[23:0];
			ceps_pkg::REG_HIGHLIGHT:   model_cfg.highlight_mode = data[1:0];
			ceps_pkg::REG_EYELID_ROWS: model_cfg.eyelid_rows    = data[7:0];
			ceps_pkg::REG_CLOSED_EYE:  model_cfg.closed_eye     = data[0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	// junk in the unused upper bits must be dropped by the block
	task automatic apply_cfg(input ceps_pkg::cfg_t c);
		logic [23:0] junk;
		junk = 24'($urandom);
		write_reg(ceps_pkg::REG_PUPIL_DX, {junk[23:6], c.pupil_dx});
		junk = 24'($urandom);
		write_reg(ceps_pkg::REG_PUPIL_DY, {junk[23:6], c.pupil_dy});
		write_reg(ceps_pkg::REG_IRIS_RGB, c.iris_rgb);
		junk = 24'($urandom);
		write_reg(ceps_pkg::REG_HIGHLIGHT, {junk[23:2], c.highlight_mode});
		junk = 24'($urandom);
		write_reg(ceps_pkg::REG_EYELID_ROWS, {junk[23:8], c.eyelid_rows});
		junk = 24'($urandom);
		write_reg(ceps_pkg::REG_CLOSED_EYE, {junk[23:1], c.closed_eye});
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (expected_colors.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic send_pixel(input logic [7:0] x, input logic [7:0] y,
			input logic typed, input logic [23:0] rgb);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		pixel_x  <= x;
		pixel_y  <= y;
		do @(posedge clk); while (in_stall);
		expected_colors.push_back(typed ? rgb : pixel_color(x, y));
		@(negedge clk);
	endtask

	initial begin
		logic [15:0] xy;
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = ceps_pkg::REG_PUPIL_DX;
		cfg_data       = '0;
		in_valid       = 1'b0;
		pixel_x        = 8'd0;
		pixel_y        = 8'd0;
		out_stall      = 1'b0;
		error_count    = 0;
		cycle_count    = 0;
		send_idle_pct  = 25;
		sink_stall_pct = 57;
		model_cfg      = '{6'd0, 6'd0, ceps_pkg::IRIS_RESET, ceps_pkg::HL_DOT, 8'd0, 1'b0};

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < PROBE_COUNT; i++) begin
			if (i == CLOSED_FIRST) begin
				drain();
				write_reg(ceps_pkg::REG_CLOSED_EYE, 24'd1);
				cfg_we <= 1'b0;
			end
			send_pixel(PROBES[i].x, PROBES[i].y, PROBES[i].typed, PROBES[i].rgb);
		end

		for (int p = 0; p < PHASE_COUNT; p++) begin
			drain();
			if (p < 4) begin
				send_idle_pct  = 25;
				sink_stall_pct = 57;
			end else if (p < 8) begin
				send_idle_pct  = 57;
				sink_stall_pct = 25;
			end else begin
				send_idle_pct  = 0;
				sink_stall_pct = 0;
			end
			apply_cfg(PHASE_CFG[p]);
			if (p == 0) begin
				write_reg(REG_SPARE_6, ceps_pkg::CFG_DW'($urandom));
				write_reg(REG_SPARE_7, ceps_pkg::CFG_DW'($urandom));
			end
			cfg_we <= 1'b0;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// halfway through phase 1, hold off until the pipeline is empty
				if (p == 1 && n == ITEMS_PER_PHASE / 2)
					drain();
				xy = random_pixel();
				send_pixel(xy[15:8], xy[7:0], 1'b0, ceps_pkg::BLACK_RGB);
			end
		end

		drain();
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
